// ===== rtl/tpc_pkg.sv =====
// shared constants and register codes for the triangle pixel coverage test
`timescale 1ns / 1ps

package tpc_pkg;

  // fixed point format of the vertex coordinates
  localparam int FRAC_BITS = 16;
  localparam int FP_ONE    = 1 << FRAC_BITS;
  localparam int FP_HALF   = 1 << (FRAC_BITS - 1);

  // field widths
  localparam int COORD_W = 32;
  localparam int PIX_W   = 13;
  localparam int SCR_W   = 14;
  localparam int ADDR_W  = 26;
  localparam int COLOR_W = 24;
  localparam int EDGE_W  = 64;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CLIP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CLIP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE  = 2'd2;

  // register reset values
  localparam logic [SCR_W-1:0] RST_CLIP_WIDTH  = 14'd640;
  localparam logic [SCR_W-1:0] RST_CLIP_HEIGHT = 14'd480;
  localparam logic [SCR_W-1:0] RST_ROW_STRIDE  = 14'd640;

  // register stages from input to result
  localparam int PIPE_DEPTH = 5;

endpackage

// ===== rtl/tpc_pix_if.sv =====
// valid/ready channels for triangle items and pixel results
`timescale 1ns / 1ps

interface tpc_pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vert0_x;
  logic [31:0] vert0_y;
  logic [31:0] vert1_x;
  logic [31:0] vert1_y;
  logic [31:0] vert2_x;
  logic [31:0] vert2_y;
  logic [23:0] fill_color;
  logic [12:0] pixel_x;
  logic [12:0] pixel_y;

  modport source (
    output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
           fill_color, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
           fill_color, pixel_x, pixel_y,
    output ready
  );
endinterface

interface tpc_pix_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [25:0] pixel_address;
  logic [23:0] pixel_color;

  modport source (
    output valid, write_enable, pixel_address, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, pixel_color,
    output ready
  );
endinterface

// ===== rtl/triangle_pixel_coverage_test_top.sv =====
// triangle pixel coverage test: edge functions, bounding box clip and address
`timescale 1ns / 1ps

// Takes one triangle and one pixel per beat and returns one result beat per item:
// a write flag, the linear address pixel_y*row_stride+pixel_x and the fill color.
// The datapath is five register stages (operand differences, partial products,
// product sums, edge sums, sign test), and a new item can be taken every cycle
// while the output does not stall; the rate is set by the twelve 33x18- and
// 33x17-bit partial product multipliers, one bank per item. Stalls
// on the output back up through per-stage enables; the result register keeps
// the last stage, so input stays ready while any stage still holds a bubble.
// Registers (APB, 4-byte spacing): clip width at 0x0, clip height at 0x4,
// row_stride at 0x8; write them only while no item is in flight.
module triangle_pixel_coverage_test_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tpc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  tpc_pix_in_if.sink                   pix_in,
  tpc_pix_out_if.source                pix_out
);

  localparam int SW = tpc_pkg::SCR_W;
  localparam int PW = tpc_pkg::PIX_W;
  localparam int CW = tpc_pkg::COLOR_W;
  localparam int AW = tpc_pkg::ADDR_W;
  localparam int EW = tpc_pkg::EDGE_W;

  // configuration registers
  logic [SW-1:0] clip_width;
  logic [SW-1:0] clip_height;
  logic [SW-1:0] row_stride;
  logic [1:0]    reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_width  <= tpc_pkg::RST_CLIP_WIDTH;
      clip_height <= tpc_pkg::RST_CLIP_HEIGHT;
      row_stride  <= tpc_pkg::RST_ROW_STRIDE;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        tpc_pkg::REG_CLIP_WIDTH:  clip_width  <= pwdata[SW-1:0];
        tpc_pkg::REG_CLIP_HEIGHT: clip_height <= pwdata[SW-1:0];
        tpc_pkg::REG_ROW_STRIDE:  row_stride  <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_index)
      tpc_pkg::REG_CLIP_WIDTH:  prdata = {{(tpc_pkg::PDATA_W-SW){1'b0}}, clip_width};
      tpc_pkg::REG_CLIP_HEIGHT: prdata = {{(tpc_pkg::PDATA_W-SW){1'b0}}, clip_height};
      tpc_pkg::REG_ROW_STRIDE:  prdata = {{(tpc_pkg::PDATA_W-SW){1'b0}}, row_stride};
      default:                  prdata = '0;
    endcase
  end

  // stage enables: a stage loads when it is empty or its successor moves
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || pix_out.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix_in.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= pix_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1 inputs: vertices per edge (a -> b) and the pixel centre
  logic signed [31:0] vx [3];
  logic signed [31:0] vy [3];
  logic        [28:0] cx, cy;

  assign vx[0] = $signed(pix_in.vert0_x);
  assign vy[0] = $signed(pix_in.vert0_y);
  assign vx[1] = $signed(pix_in.vert1_x);
  assign vy[1] = $signed(pix_in.vert1_y);
  assign vx[2] = $signed(pix_in.vert2_x);
  assign vy[2] = $signed(pix_in.vert2_y);
  assign cx = {pix_in.pixel_x, 16'(tpc_pkg::FP_HALF)};
  assign cy = {pix_in.pixel_y, 16'(tpc_pkg::FP_HALF)};

  // min and max of the vertex coordinates for the box
  logic signed [31:0] xmin_c, xmax_c, ymin_c, ymax_c;
  always_comb begin
    xmin_c = vx[0];
    if (vx[1] < xmin_c) xmin_c = vx[1];
    if (vx[2] < xmin_c) xmin_c = vx[2];
    xmax_c = vx[0];
    if (vx[1] > xmax_c) xmax_c = vx[1];
    if (vx[2] > xmax_c) xmax_c = vx[2];
    ymin_c = vy[0];
    if (vy[1] < ymin_c) ymin_c = vy[1];
    if (vy[2] < ymin_c) ymin_c = vy[2];
    ymax_c = vy[0];
    if (vy[1] > ymax_c) ymax_c = vy[1];
    if (vy[2] > ymax_c) ymax_c = vy[2];
  end

  // stage 1: edge coefficients and centre offsets from the start vertex
  logic signed [32:0] s1_ex [3];
  logic signed [32:0] s1_ey [3];
  logic signed [33:0] s1_dx [3];
  logic signed [33:0] s1_dy [3];
  logic signed [31:0] s1_xmin, s1_xmax, s1_ymin, s1_ymax;
  logic [PW-1:0]      s1_px, s1_py;
  logic [CW-1:0]      s1_color;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        s1_ex[k] <= {vy[(k+1)%3][31], vy[(k+1)%3]} - {vy[k][31], vy[k]};
        s1_ey[k] <= {vx[k][31], vx[k]} - {vx[(k+1)%3][31], vx[(k+1)%3]};
        s1_dx[k] <= $signed({5'b0, cx}) - {{2{vx[k][31]}}, vx[k]};
        s1_dy[k] <= $signed({5'b0, cy}) - {{2{vy[k][31]}}, vy[k]};
      end
      s1_xmin  <= xmin_c;
      s1_xmax  <= xmax_c;
      s1_ymin  <= ymin_c;
      s1_ymax  <= ymax_c;
      s1_px    <= pix_in.pixel_x;
      s1_py    <= pix_in.pixel_y;
      s1_color <= pix_in.fill_color;
    end
  end

  // box ceilings in 33 bits so the round-up cannot overflow
  logic signed [32:0] xceil_sum, yceil_sum;
  assign xceil_sum = {s1_xmax[31], s1_xmax} + 33'(tpc_pkg::FP_ONE - 1);
  assign yceil_sum = {s1_ymax[31], s1_ymax} + 33'(tpc_pkg::FP_ONE - 1);

  // stage 2: partial products (offset split at bit 17), box bounds, row base
  logic signed [50:0] s2_xlo [3];
  logic signed [49:0] s2_xhi [3];
  logic signed [50:0] s2_ylo [3];
  logic signed [49:0] s2_yhi [3];
  logic signed [15:0] s2_xfl, s2_yfl;
  logic signed [16:0] s2_xcl, s2_ycl;
  logic [AW-1:0]      s2_row;
  logic [PW-1:0]      s2_px, s2_py;
  logic [CW-1:0]      s2_color;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        s2_xlo[k] <= s1_ex[k] * $signed({1'b0, s1_dx[k][16:0]});
        s2_xhi[k] <= s1_ex[k] * $signed(s1_dx[k][33:17]);
        s2_ylo[k] <= s1_ey[k] * $signed({1'b0, s1_dy[k][16:0]});
        s2_yhi[k] <= s1_ey[k] * $signed(s1_dy[k][33:17]);
      end
      s2_xfl   <= s1_xmin[31:16];
      s2_yfl   <= s1_ymin[31:16];
      s2_xcl   <= xceil_sum[32:16];
      s2_ycl   <= yceil_sum[32:16];
      s2_row   <= AW'(s1_py * row_stride);
      s2_px    <= s1_px;
      s2_py    <= s1_py;
      s2_color <= s1_color;
    end
  end

  // box test with the screen clip; the lower clip at zero always holds
  logic signed [17:0] px_s, py_s;
  logic               in_box_c;
  assign px_s = $signed({5'b0, s2_px});
  assign py_s = $signed({5'b0, s2_py});
  assign in_box_c = (px_s >= $signed({{2{s2_xfl[15]}}, s2_xfl})) &&
                    (px_s <  $signed({s2_xcl[16], s2_xcl})) &&
                    ({1'b0, s2_px} < clip_width) &&
                    (py_s >= $signed({{2{s2_yfl[15]}}, s2_yfl})) &&
                    (py_s <  $signed({s2_ycl[16], s2_ycl})) &&
                    ({1'b0, s2_py} < clip_height);

  // stage 3: join the partial products modulo 2^64
  logic [EW-1:0] s3_tx [3];
  logic [EW-1:0] s3_ty [3];
  logic          s3_in_box;
  logic [AW-1:0] s3_addr;
  logic [CW-1:0] s3_color;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int k = 0; k < 3; k++) begin
        s3_tx[k] <= {{13{s2_xlo[k][50]}}, s2_xlo[k]} + {s2_xhi[k][46:0], 17'b0};
        s3_ty[k] <= {{13{s2_ylo[k][50]}}, s2_ylo[k]} + {s2_yhi[k][46:0], 17'b0};
      end
      s3_in_box <= in_box_c;
      s3_addr   <= s2_row + AW'(s2_px);
      s3_color  <= s2_color;
    end
  end

  // stage 4: edge values
  logic [EW-1:0] s4_edge [3];
  logic          s4_in_box;
  logic [AW-1:0] s4_addr;
  logic [CW-1:0] s4_color;

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int k = 0; k < 3; k++) begin
        s4_edge[k] <= s3_tx[k] + s3_ty[k];
      end
      s4_in_box <= s3_in_box;
      s4_addr   <= s3_addr;
      s4_color  <= s3_color;
    end
  end

  // sign test, either winding accepted, zero counts for both
  logic [2:0] neg, zero;
  logic       inside_c;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k]  = s4_edge[k][EW-1];
      zero[k] = (s4_edge[k] == '0);
    end
    inside_c = (neg == 3'b000) || ((neg | zero) == 3'b111);
  end

  // stage 5: result register
  logic          s5_we;
  logic [AW-1:0] s5_addr;
  logic [CW-1:0] s5_color;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_we    <= s4_in_box && inside_c;
      s5_addr  <= s4_addr;
      s5_color <= s4_color;
    end
  end

  assign pix_out.valid         = v5;
  assign pix_out.write_enable  = s5_we;
  assign pix_out.pixel_address = s5_addr;
  assign pix_out.pixel_color   = s5_color;

endmodule

// ===== rtl/tpc_checker.sv =====
// port-level checks for the triangle pixel coverage test, bound to the top
`timescale 1ns / 1ps

module tpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_enable,
  input logic [25:0] pixel_address,
  input logic [23:0] pixel_color
);

  localparam int DEPTH = tpc_pkg::PIPE_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  // items accepted whose result beat has not gone out yet
  logic [CNT_W-1:0] in_flight;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_beat) - CNT_W'(out_beat);
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_enable) &&
      $stable(pixel_address) && $stable(pixel_color))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // no result without an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != '0)
    else $error("result beat without a pending item");

  // the pipeline never holds more than its stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(DEPTH))
    else $error("more items in flight than pipeline stages");

  // with the result register empty every stage can move, so input is ready
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind triangle_pixel_coverage_test_top tpc_checker u_tpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pix_in.valid),
  .in_ready      (pix_in.ready),
  .out_valid     (pix_out.valid),
  .out_ready     (pix_out.ready),
  .write_enable  (pix_out.write_enable),
  .pixel_address (pix_out.pixel_address),
  .pixel_color   (pix_out.pixel_color)
);

// ===== dv/tb_triangle_pixel_coverage_test_top.sv =====
// self-checking testbench for the triangle pixel coverage test top level
`timescale 1ns / 1ps

module tb_triangle_pixel_coverage_test_top;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 80;
  localparam int NUM_PHASES  = 9;

  typedef struct packed {
    logic [tpc_pkg::COORD_W-1:0] v0x;
    logic [tpc_pkg::COORD_W-1:0] v0y;
    logic [tpc_pkg::COORD_W-1:0] v1x;
    logic [tpc_pkg::COORD_W-1:0] v1y;
    logic [tpc_pkg::COORD_W-1:0] v2x;
    logic [tpc_pkg::COORD_W-1:0] v2y;
    logic [tpc_pkg::COLOR_W-1:0] color;
    logic [tpc_pkg::PIX_W-1:0]   px;
    logic [tpc_pkg::PIX_W-1:0]   py;
  } tri_item_t;

  typedef struct packed {
    logic                        we;
    logic [tpc_pkg::ADDR_W-1:0]  addr;
    logic [tpc_pkg::COLOR_W-1:0] color;
  } pix_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tpc_pkg::PADDR_W-1:0] paddr;
  logic [tpc_pkg::PDATA_W-1:0] pwdata;
  logic [tpc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  tpc_pix_in_if  pix_in ();
  tpc_pix_out_if pix_out ();

  triangle_pixel_coverage_test_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_in  (pix_in.sink),
    .pix_out (pix_out.source)
  );

  // register copies used by the predictor
  bit [tpc_pkg::SCR_W-1:0] cfg_width;
  bit [tpc_pkg::SCR_W-1:0] cfg_height;
  bit [tpc_pkg::SCR_W-1:0] cfg_stride;

  tri_item_t   tri_queue[$];
  pix_result_t due_pixels[$];
  int          errors;
  bit          no_idle;
  bit          in_fire;
  bit          out_fire;
  int          send_gap;
  int          recv_stall;
  int          idle_cycles;
  tri_item_t   drv_item;
  tri_item_t   mon_item;
  pix_result_t mon_exp;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // edge function of the edge a->b at point p, all modulo 2^64
  function automatic bit [63:0] edge_val(bit [63:0] xa, bit [63:0] ya, bit [63:0] xb,
                                         bit [63:0] yb, bit [63:0] px, bit [63:0] py);
    bit [63:0] ex;
    bit [63:0] ey;
    bit [63:0] c;
    ex = yb - ya;
    ey = xa - xb;
    c  = ex * xa + ey * ya;
    return ex * px + ey * py - c;
  endfunction

  // write flag, address and color for one triangle and pixel
  function automatic pix_result_t pixel_outcome(tri_item_t t);
    longint x0, y0, x1, y1, x2, y2;
    longint lox, hix, loy, hiy;
    bit [63:0] cx, cy, e0, e1, e2;
    bit inbox, all_pos, all_neg;
    bit [31:0] lin;
    pix_result_t r;
    x0 = longint'($signed(t.v0x));
    y0 = longint'($signed(t.v0y));
    x1 = longint'($signed(t.v1x));
    y1 = longint'($signed(t.v1y));
    x2 = longint'($signed(t.v2x));
    y2 = longint'($signed(t.v2y));
    // bounding box: floor of minima, ceiling of maxima
    lox = x0; if (x1 < lox) lox = x1; if (x2 < lox) lox = x2;
    hix = x0; if (x1 > hix) hix = x1; if (x2 > hix) hix = x2;
    loy = y0; if (y1 < loy) loy = y1; if (y2 < loy) loy = y2;
    hiy = y0; if (y1 > hiy) hiy = y1; if (y2 > hiy) hiy = y2;
    lox = lox >>> tpc_pkg::FRAC_BITS;
    loy = loy >>> tpc_pkg::FRAC_BITS;
    hix = (hix + tpc_pkg::FP_ONE - 1) >>> tpc_pkg::FRAC_BITS;
    hiy = (hiy + tpc_pkg::FP_ONE - 1) >>> tpc_pkg::FRAC_BITS;
    // clip to the screen
    if (lox < 0) lox = 0;
    if (loy < 0) loy = 0;
    if (hix > longint'(cfg_width)) hix = longint'(cfg_width);
    if (hiy > longint'(cfg_height)) hiy = longint'(cfg_height);
    inbox = longint'(t.px) >= lox && longint'(t.px) < hix &&
            longint'(t.py) >= loy && longint'(t.py) < hiy;
    // edge values at the pixel center
    cx = (64'(t.px) << tpc_pkg::FRAC_BITS) + 64'(tpc_pkg::FP_HALF);
    cy = (64'(t.py) << tpc_pkg::FRAC_BITS) + 64'(tpc_pkg::FP_HALF);
    e0 = edge_val(64'(x0), 64'(y0), 64'(x1), 64'(y1), cx, cy);
    e1 = edge_val(64'(x1), 64'(y1), 64'(x2), 64'(y2), cx, cy);
    e2 = edge_val(64'(x2), 64'(y2), 64'(x0), 64'(y0), cx, cy);
    all_pos = !e0[63] && !e1[63] && !e2[63];
    all_neg = (e0[63] || e0 == 0) && (e1[63] || e1 == 0) && (e2[63] || e2 == 0);
    lin = 32'(t.py) * 32'(cfg_stride) + 32'(t.px);
    r.we    = inbox && (all_pos || all_neg);
    r.addr  = lin[tpc_pkg::ADDR_W-1:0];
    r.color = t.color;
    return r;
  endfunction

  function automatic logic [tpc_pkg::PIX_W-1:0] pix_clamp(longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > 8191) c = 8191;
    return c[tpc_pkg::PIX_W-1:0];
  endfunction

  // random triangle: mostly small ones near the visible area, some noise, some range extremes
  function automatic tri_item_t rand_tri();
    tri_item_t t;
    longint span_w, span_h, cxp, cyp, s;
    longint vx[3];
    longint vy[3];
    logic [31:0] rnd;
    int k;
    k = $urandom_range(0, 9);
    rnd = $urandom;
    t.color = rnd[tpc_pkg::COLOR_W-1:0];
    if (k < 8) begin
      span_w = (cfg_width == 0) ? 1 : ((cfg_width > 8191) ? 8191 : cfg_width);
      span_h = (cfg_height == 0) ? 1 : ((cfg_height > 8191) ? 8191 : cfg_height);
      cxp = $urandom_range(0, span_w);
      cyp = $urandom_range(0, span_h);
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 32);
      for (int i = 0; i < 3; i++) begin
        vx[i] = (cxp << tpc_pkg::FRAC_BITS) - s * tpc_pkg::FP_ONE +
                longint'($urandom_range(0, 2 * s * tpc_pkg::FP_ONE));
        vy[i] = (cyp << tpc_pkg::FRAC_BITS) - s * tpc_pkg::FP_ONE +
                longint'($urandom_range(0, 2 * s * tpc_pkg::FP_ONE));
        // snapped vertices make exact edge hits more likely
        if ($urandom_range(0, 3) == 0) begin
          vx[i] = vx[i] & ~longint'(tpc_pkg::FP_ONE - 1);
          vy[i] = vy[i] & ~longint'(tpc_pkg::FP_ONE - 1);
        end
      end
      t.v0x = vx[0][31:0]; t.v0y = vy[0][31:0];
      t.v1x = vx[1][31:0]; t.v1y = vy[1][31:0];
      t.v2x = vx[2][31:0]; t.v2y = vy[2][31:0];
      t.px = pix_clamp(cxp + longint'($urandom_range(0, 2 * s)) - s);
      t.py = pix_clamp(cyp + longint'($urandom_range(0, 2 * s)) - s);
    end else if (k == 8) begin
      t.v0x = $urandom; t.v0y = $urandom;
      t.v1x = $urandom; t.v1y = $urandom;
      t.v2x = $urandom; t.v2y = $urandom;
      t.px = pix_clamp(longint'($urandom_range(0, 8191)));
      t.py = pix_clamp(longint'($urandom_range(0, 8191)));
    end else begin
      // coordinates at the ends of the range
      t.v0x = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      t.v0y = $urandom_range(0, 1) ? 32'h8000_0000 : $urandom;
      t.v1x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom;
      t.v1y = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
      t.v2x = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
      t.v2y = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      t.px = $urandom_range(0, 1) ? pix_clamp(8191) :
                                    pix_clamp(longint'($urandom_range(0, 8191)));
      t.py = $urandom_range(0, 1) ? pix_clamp(0) :
                                    pix_clamp(longint'($urandom_range(0, 8191)));
    end
    return t;
  endfunction

  task automatic push_tri(int ax, int ay, int bx, int by, int cx, int cy,
                          int color, int px, int py);
    tri_item_t t;
    t.v0x = ax; t.v0y = ay;
    t.v1x = bx; t.v1y = by;
    t.v2x = cx; t.v2y = cy;
    t.color = color[tpc_pkg::COLOR_W-1:0];
    t.px = px[tpc_pkg::PIX_W-1:0];
    t.py = py[tpc_pkg::PIX_W-1:0];
    tri_queue.push_back(t);
  endtask

  // wait until every item has gone through and the pipeline is empty
  task automatic wait_drained();
    while (tri_queue.size() != 0 || pix_in.valid || due_pixels.size() != 0)
      @(posedge clk);
    repeat (tpc_pkg::PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, bit [tpc_pkg::SCR_W-1:0] val);
    logic [tpc_pkg::PDATA_W-1:0] d;
    d = $urandom;
    d[tpc_pkg::SCR_W-1:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tpc_pkg::REG_CLIP_WIDTH:  cfg_width  = val;
      tpc_pkg::REG_CLIP_HEIGHT: cfg_height = val;
      tpc_pkg::REG_ROW_STRIDE:  cfg_stride = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(logic [1:0] idx, bit [tpc_pkg::SCR_W-1:0] want);
    logic [tpc_pkg::PDATA_W-1:0] got;
    logic [tpc_pkg::PDATA_W-1:0] exp_val;
    exp_val = '0;
    exp_val[tpc_pkg::SCR_W-1:0] = want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== exp_val) begin
      errors++;
      $display("%0t register %0d readback: expected %h actual %h", $time, idx,
               exp_val, got);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_check_all();
    cfg_read(tpc_pkg::REG_CLIP_WIDTH, cfg_width);
    cfg_read(tpc_pkg::REG_CLIP_HEIGHT, cfg_height);
    cfg_read(tpc_pkg::REG_ROW_STRIDE, cfg_stride);
  endtask

  task automatic cfg_set(int w, int h, int s);
    cfg_write(tpc_pkg::REG_CLIP_WIDTH, w[tpc_pkg::SCR_W-1:0]);
    cfg_write(tpc_pkg::REG_CLIP_HEIGHT, h[tpc_pkg::SCR_W-1:0]);
    cfg_write(tpc_pkg::REG_ROW_STRIDE, s[tpc_pkg::SCR_W-1:0]);
    cfg_check_all();
  endtask

  // item driver: one beat per queued triangle, random gap after each unless no_idle is set
  always @(negedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
    end else if (pix_in.valid && !in_fire) begin
      // hold the beat until it is taken
    end else if (send_gap > 0) begin
      send_gap--;
      pix_in.valid <= 1'b0;
    end else if (tri_queue.size() != 0) begin
      drv_item = tri_queue.pop_front();
      pix_in.vert0_x    <= drv_item.v0x;
      pix_in.vert0_y    <= drv_item.v0y;
      pix_in.vert1_x    <= drv_item.v1x;
      pix_in.vert1_y    <= drv_item.v1y;
      pix_in.vert2_x    <= drv_item.v2x;
      pix_in.vert2_y    <= drv_item.v2y;
      pix_in.fill_color <= drv_item.color;
      pix_in.pixel_x    <= drv_item.px;
      pix_in.pixel_y    <= drv_item.py;
      pix_in.valid      <= 1'b1;
      send_gap = no_idle ? 0 : $urandom_range(0, 19);
    end else begin
      pix_in.valid <= 1'b0;
    end
  end

  // result receiver: random stall after each beat unless no_idle is set
  always @(negedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (out_fire) recv_stall = no_idle ? 0 : $urandom_range(0, 19);
      if (recv_stall > 0) begin
        recv_stall--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    in_fire  = !rst && pix_in.valid && pix_in.ready;
    out_fire = !rst && pix_out.valid && pix_out.ready;
    if (out_fire) begin
      if (due_pixels.size() == 0) begin
        errors++;
        $display("%0t result beat with none expected: expected none actual %h %h %h",
                 $time, pix_out.write_enable, pix_out.pixel_address, pix_out.pixel_color);
      end else begin
        mon_exp = due_pixels.pop_front();
        if (pix_out.write_enable !== mon_exp.we) begin
          errors++;
          $display("%0t write_enable: expected %h actual %h", $time, mon_exp.we,
                   pix_out.write_enable);
        end
        if (pix_out.pixel_address !== mon_exp.addr) begin
          errors++;
          $display("%0t pixel_address: expected %h actual %h", $time, mon_exp.addr,
                   pix_out.pixel_address);
        end
        if (pix_out.pixel_color !== mon_exp.color) begin
          errors++;
          $display("%0t pixel_color: expected %h actual %h", $time, mon_exp.color,
                   pix_out.pixel_color);
        end
      end
    end
    if (in_fire) begin
      mon_item.v0x   = pix_in.vert0_x;
      mon_item.v0y   = pix_in.vert0_y;
      mon_item.v1x   = pix_in.vert1_x;
      mon_item.v1y   = pix_in.vert1_y;
      mon_item.v2x   = pix_in.vert2_x;
      mon_item.v2y   = pix_in.vert2_y;
      mon_item.color = pix_in.fill_color;
      mon_item.px    = pix_in.pixel_x;
      mon_item.py    = pix_in.pixel_y;
      due_pixels.push_back(pixel_outcome(mon_item));
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    int w, h, s;
    errors      = 0;
    no_idle     = 1'b0;
    in_fire     = 1'b0;
    out_fire    = 1'b0;
    send_gap    = 0;
    recv_stall  = 0;
    idle_cycles = 0;
    cfg_width   = tpc_pkg::RST_CLIP_WIDTH;
    cfg_height  = tpc_pkg::RST_CLIP_HEIGHT;
    cfg_stride  = tpc_pkg::RST_ROW_STRIDE;
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    pix_in.valid      = 1'b0;
    pix_in.vert0_x    = '0;
    pix_in.vert0_y    = '0;
    pix_in.vert1_x    = '0;
    pix_in.vert1_y    = '0;
    pix_in.vert2_x    = '0;
    pix_in.vert2_y    = '0;
    pix_in.fill_color = '0;
    pix_in.pixel_x    = '0;
    pix_in.pixel_y    = '0;
    pix_out.ready     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values of the registers
    cfg_check_all();

    // directed: both windings, box edges, clipping, degenerate shapes, extremes
    push_tri(10 << 16, 10 << 16, 50 << 16, 10 << 16, 10 << 16, 50 << 16, 'h123456, 20, 20);
    push_tri(10 << 16, 10 << 16, 10 << 16, 50 << 16, 50 << 16, 10 << 16, 'h654321, 20, 20);
    push_tri(10 << 16, 10 << 16, 50 << 16, 10 << 16, 10 << 16, 50 << 16, 'hABCDEF, 45, 45);
    push_tri(10 << 16, 10 << 16, 50 << 16, 10 << 16, 10 << 16, 50 << 16, 'h0000FF, 60, 20);
    push_tri(10 << 16, 10 << 16, 50 << 16, 10 << 16, 10 << 16, 50 << 16, 'h00FF00, 10, 10);
    push_tri(10 << 16, 10 << 16, 50 << 16, 10 << 16, 10 << 16, 50 << 16, 'hFF0000, 49, 10);
    push_tri(10 << 16, 10 << 16, 50 << 16, 10 << 16, 10 << 16, 50 << 16, 'h111111, 50, 10);
    // single point off the integer grid
    push_tri('h38000, 'h38000, 'h38000, 'h38000, 'h38000, 'h38000, 'h222222, 3, 3);
    // collinear vertices, pixel center on and off the line
    push_tri(0, 0, 10 << 16, 10 << 16, 20 << 16, 20 << 16, 'h333333, 5, 5);
    push_tri(0, 0, 10 << 16, 10 << 16, 20 << 16, 20 << 16, 'h444444, 5, 6);
    // box clipped at zero
    push_tri(-100 << 16, -100 << 16, 100 << 16, -100 << 16, -100 << 16, 100 << 16,
             'h555555, 0, 0);
    // box clipped at the screen size
    push_tri(-1000 << 16, -1000 << 16, 5000 << 16, -1000 << 16, -1000 << 16, 5000 << 16,
             'h666666, 639, 479);
    push_tri(-1000 << 16, -1000 << 16, 5000 << 16, -1000 << 16, -1000 << 16, 5000 << 16,
             'h777777, 640, 0);
    push_tri(-1000 << 16, -1000 << 16, 5000 << 16, -1000 << 16, -1000 << 16, 5000 << 16,
             'h888888, 0, 480);
    // negative fractional vertex floors below zero
    push_tri('hFFFF8000, 'hFFFF8000, 30 << 16, 0, 0, 30 << 16, 'h999999, 0, 0);
    // coordinate extremes with edge overflow
    push_tri('h80000000, 'h80000000, 'h7FFFFFFF, 'h80000000, 'h80000000, 'h7FFFFFFF,
             'hFFFFFF, 8191, 8191);
    push_tri('h80000000, 'h80000000, 'h7FFFFFFF, 'h80000000, 'h80000000, 'h7FFFFFFF,
             'h000000, 0, 0);
    push_tri('h7FFFFFFF, 'h80000000, 'h80000000, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF,
             'hFFFFFF, 320, 240);
    push_tri('h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF,
             'h0F0F0F, 8191, 0);
    push_tri('h80000000, 'h80000000, 'h80000000, 'h80000000, 'h80000000, 'h80000000,
             'hF0F0F0, 0, 8191);
    push_tri(0, 0, 'h7FFFFFFF, 0, 0, 'h7FFFFFFF, 'hA5A5A5, 100, 100);
    wait_drained();

    // random phases over register settings, extremes included
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 0;     h = 480;   s = 640;   end
        1: begin w = 1;     h = 1;     s = 1;     end
        2: begin w = 8192;  h = 8192;  s = 8192;  end
        3: begin w = 16383; h = 16383; s = 16383; end
        4: begin w = 100;   h = 0;     s = 0;     end
        5: begin w = 640;   h = 480;   s = 640;   end
        default: begin
          w = $urandom_range(1, 8192);
          h = $urandom_range(1, 8192);
          s = $urandom_range(1, 8192);
        end
      endcase
      cfg_set(w, h, s);
      no_idle = (p % 3 == 1);
      repeat (PHASE_ITEMS) tri_queue.push_back(rand_tri());
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
